// ===== rtl/tci_pkg.sv =====
package tci_pkg;

   // Fixed point format
   localparam int FRAC_BITS = 16;
   localparam int FIELD_W   = 17;
   localparam logic [FIELD_W-1:0] ONE_Q = FIELD_W'(1 << FRAC_BITS);

   // Datapath widths
   localparam int DEN_W  = FIELD_W + 1;        // signed knot or throttle difference
   localparam int FV_W   = 37;                 // saturated value, +-(2^36 - 1)
   localparam int PROD_W = DEN_W + FV_W;       // difference times value
   localparam int NUM_W  = PROD_W + 1;         // difference of two products
   localparam int MAG_W  = NUM_W - 1;
   localparam int QBITS  = FV_W - 1;           // quotient bits below saturation
   localparam int REM_W  = FIELD_W;            // partial remainder, below divisor
   localparam logic [QBITS-1:0] SAT_MAG = '1;

   // Pipeline depth
   localparam int DIV_LAT   = QBITS + 2;       // entry stage, cells, result stage
   localparam int LEVEL_LAT = DIV_LAT + 2;     // products, numerator, divider
   localparam int NUM_LVL   = 4;
   localparam int TL_LEN    = NUM_LVL * LEVEL_LAT;
   localparam int TOTAL_LAT = TL_LEN + 4;      // plus linear merge and blend

   // Register file
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_KNOT_X1      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KNOT_X2      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KNOT_X3      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KNOT_Y1      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KNOT_Y2      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KNOT_Y3      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_FACTOR = 3'd6;

   localparam logic [FIELD_W-1:0] RST_KNOT_X1 = 17'd16384;
   localparam logic [FIELD_W-1:0] RST_KNOT_X2 = 17'd32768;
   localparam logic [FIELD_W-1:0] RST_KNOT_X3 = 17'd49152;
   localparam logic [FIELD_W-1:0] RST_KNOT_Y1 = 17'd16384;
   localparam logic [FIELD_W-1:0] RST_KNOT_Y2 = 17'd32768;
   localparam logic [FIELD_W-1:0] RST_KNOT_Y3 = 17'd49152;
   localparam logic [FIELD_W-1:0] RST_BLEND   = 17'd0;

   // State carried by one divider cell
   typedef struct packed {
      logic [REM_W-1:0] rem;     // partial remainder
      logic [QBITS-1:0] low;     // dividend bits out, quotient bits in
      logic [REM_W-1:0] dmag;    // divisor magnitude
      logic             neg;     // quotient sign
      logic             ovf;     // quotient saturates
   } cell_type;

   // Linear segment chosen for one throttle value
   typedef struct packed {
      logic [FIELD_W-1:0] xa;
      logic [FIELD_W-1:0] ya;
      logic [FIELD_W-1:0] xb;
      logic [FIELD_W-1:0] yb;
      logic               eq;    // throttle sits on the second knot
   } seg_type;

   typedef struct packed {
      logic [FIELD_W-1:0] curve;
      logic               clamped;
      logic               degen;
   } result_type;

   function automatic logic signed [DEN_W-1:0] tci_diff(input logic [FIELD_W-1:0] a,
                                                       input logic [FIELD_W-1:0] b);
      tci_diff = $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   function automatic seg_type tci_pick_seg(input logic [FIELD_W-1:0] t,
                                            input logic [FIELD_W-1:0] x1,
                                            input logic [FIELD_W-1:0] x2,
                                            input logic [FIELD_W-1:0] x3,
                                            input logic [FIELD_W-1:0] y1,
                                            input logic [FIELD_W-1:0] y2,
                                            input logic [FIELD_W-1:0] y3);
      seg_type s;
      s.eq = 1'b0;
      if (t < x1) begin
         s.xa = '0;  s.ya = '0;  s.xb = x1;    s.yb = y1;
      end else if (t > x3) begin
         s.xa = x3;  s.ya = y3;  s.xb = ONE_Q; s.yb = ONE_Q;
      end else if (t > x2) begin
         s.xa = x2;  s.ya = y2;  s.xb = x3;    s.yb = y3;
      end else if (t > x1) begin
         s.xa = x1;  s.ya = y1;  s.xb = x2;    s.yb = y2;
      end else begin
         s.xa = x1;  s.ya = y1;  s.xb = x2;    s.yb = y2;
         s.eq = 1'b1;
      end
      tci_pick_seg = s;
   endfunction

endpackage

// ===== rtl/tci_div_cell.sv =====
module tci_div_cell import tci_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  cell_type cell_in,
   output cell_type cell_out
);

   logic [REM_W:0] trial;
   logic [REM_W:0] sub;
   logic           ge;
   cell_type       cell_in_next;
   cell_type       cell_ff;

   // one restoring step: bring down the next dividend bit
   always_comb begin
      trial        = {cell_in.rem, cell_in.low[QBITS-1]};
      sub          = trial - {1'b0, cell_in.dmag};
      ge           = (trial >= {1'b0, cell_in.dmag});
      cell_in_next = cell_in;
      cell_in_next.rem = ge ? sub[REM_W-1:0] : trial[REM_W-1:0];
      cell_in_next.low = {cell_in.low[QBITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== rtl/tci_divider.sv =====
module tci_divider import tci_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [NUM_W-1:0] num_in,
   input  logic signed [DEN_W-1:0] den_in,
   output logic signed [FV_W-1:0]  quo_out
);

   logic [NUM_W-1:0] num_abs;
   logic [DEN_W-1:0] den_abs;
   logic [MAG_W-1:0] mag;
   cell_type         entry_in;
   cell_type         entry_ff;
   cell_type         chain [0:QBITS];
   logic [QBITS-1:0] qmag;
   logic signed [FV_W-1:0] quo_in;
   logic signed [FV_W-1:0] quo_ff;

   // signs split off; quotient at or above 2^36 saturates
   always_comb begin
      num_abs       = num_in[NUM_W-1] ? NUM_W'(-num_in) : NUM_W'(num_in);
      den_abs       = den_in[DEN_W-1] ? DEN_W'(-den_in) : DEN_W'(den_in);
      mag           = num_abs[MAG_W-1:0];
      entry_in.dmag = den_abs[REM_W-1:0];
      entry_in.neg  = num_in[NUM_W-1] ^ den_in[DEN_W-1];
      entry_in.ovf  = (mag[MAG_W-1:QBITS] >= {{(MAG_W-QBITS-REM_W){1'b0}}, den_abs[REM_W-1:0]});
      entry_in.rem  = mag[QBITS+REM_W-1:QBITS];
      entry_in.low  = mag[QBITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         entry_ff <= entry_in;
      end
   end

   assign chain[0] = entry_ff;

   for (genvar k = 0; k < QBITS; k++) begin : g_cell
      tci_div_cell u_cell (
         .clock    (clock),
         .en       (en),
         .cell_in  (chain[k]),
         .cell_out (chain[k+1])
      );
   end

   always_comb begin
      qmag   = chain[QBITS].ovf ? SAT_MAG : chain[QBITS].low;
      quo_in = chain[QBITS].neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo_out = quo_ff;

endmodule

// ===== rtl/throttle_curve_interpolator.sv =====
// Throttle curve shaper. Each throttle sample is mapped through the degree-4
// polynomial over the knots (0,0), (x1,y1), (x2,y2), (x3,y3), (1,1), built
// with Neville's scheme, pulled toward the piecewise linear curve by
// blend_factor and clamped to [0,1] (Q16, 65536 = 1.0). One sample is taken
// per clock while req_stall is low. The pipeline holds the four Neville levels,
// each a row of 36 one-bit divider cells plus product, numerator, entry and
// result stages, followed by four blend stages. An output register with one
// skid entry lets one more sample in while a result waits. Knots that coincide
// give curve_out = 0 and degenerate_knots = 1. Write the registers only while
// nothing is in flight.
module throttle_curve_interpolator import tci_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // sample in
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FIELD_W-1:0]   req_throttle_in,
   // shaped result out
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [FIELD_W-1:0]   rsp_curve_out,
   output logic                 rsp_was_clamped,
   output logic                 rsp_degenerate_knots,
   // register writes
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata
);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [FIELD_W-1:0] x1_ff, x2_ff, x3_ff, y1_ff, y2_ff, y3_ff, blend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff    <= RST_KNOT_X1;
         x2_ff    <= RST_KNOT_X2;
         x3_ff    <= RST_KNOT_X3;
         y1_ff    <= RST_KNOT_Y1;
         y2_ff    <= RST_KNOT_Y2;
         y3_ff    <= RST_KNOT_Y3;
         blend_ff <= RST_BLEND;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KNOT_X1:      x1_ff    <= csr_wdata;
            CSR_KNOT_X2:      x2_ff    <= csr_wdata;
            CSR_KNOT_X3:      x3_ff    <= csr_wdata;
            CSR_KNOT_Y1:      y1_ff    <= csr_wdata;
            CSR_KNOT_Y2:      y2_ff    <= csr_wdata;
            CSR_KNOT_Y3:      y3_ff    <= csr_wdata;
            CSR_BLEND_FACTOR: blend_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [FIELD_W-1:0] kx [0:4];
   assign kx[0] = '0;
   assign kx[1] = x1_ff;
   assign kx[2] = x2_ff;
   assign kx[3] = x3_ff;
   assign kx[4] = ONE_Q;

   logic degen;
   assign degen = (x1_ff == '0) || (x2_ff == '0) || (x3_ff == '0) ||
                  (x1_ff == ONE_Q) || (x2_ff == ONE_Q) || (x3_ff == ONE_Q) ||
                  (x1_ff == x2_ff) || (x1_ff == x3_ff) || (x2_ff == x3_ff);

   // ------------------------------------------------------------------
   // Pipeline control: everything moves while the skid entry is free
   // ------------------------------------------------------------------
   logic adv;
   logic skid_v_ff, skid_v_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_LAT-1:0] vl_ff;

   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff <= '0;
      end else if (adv) begin
         vl_ff <= {vl_ff[TOTAL_LAT-2:0], req_valid};
      end
   end

   // throttle value travels beside the data
   logic [FIELD_W-1:0] tl_ff [0:TL_LEN-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         tl_ff[0] <= req_throttle_in;
         for (int k = 1; k < TL_LEN; k++) begin
            tl_ff[k] <= tl_ff[k-1];
         end
      end
   end

   logic [FIELD_W-1:0] t_lv [1:NUM_LVL];
   assign t_lv[1] = req_throttle_in;
   for (genvar lv = 2; lv <= NUM_LVL; lv++) begin : g_tlv
      assign t_lv[lv] = tl_ff[(lv-1)*LEVEL_LAT-1];
   end

   // ------------------------------------------------------------------
   // Neville levels: level lv updates f[i] for i >= lv
   // ------------------------------------------------------------------
   logic signed [FV_W-1:0] f_w [0:NUM_LVL][0:4];

   assign f_w[0][0] = '0;
   assign f_w[0][1] = $signed({{(FV_W-FIELD_W){1'b0}}, y1_ff});
   assign f_w[0][2] = $signed({{(FV_W-FIELD_W){1'b0}}, y2_ff});
   assign f_w[0][3] = $signed({{(FV_W-FIELD_W){1'b0}}, y3_ff});
   assign f_w[0][4] = $signed({{(FV_W-FIELD_W){1'b0}}, ONE_Q});

   for (genvar lv = 1; lv <= NUM_LVL; lv++) begin : g_lvl
      for (genvar i = 0; i <= 4; i++) begin : g_node
         if (i >= lv) begin : g_div
            logic signed [PROD_W-1:0] pa_ff, pb_ff;
            logic signed [NUM_W-1:0]  num_ff;
            logic signed [DEN_W-1:0]  den;

            assign den = tci_diff(kx[i], kx[i-lv]);

            always_ff @(posedge clock) begin
               if (adv) begin
                  pa_ff  <= tci_diff(t_lv[lv], kx[i-lv]) * f_w[lv-1][i];
                  pb_ff  <= tci_diff(t_lv[lv], kx[i]) * f_w[lv-1][i-1];
                  num_ff <= $signed({pa_ff[PROD_W-1], pa_ff}) -
                            $signed({pb_ff[PROD_W-1], pb_ff});
               end
            end

            tci_divider u_div (
               .clock   (clock),
               .en      (adv),
               .num_in  (num_ff),
               .den_in  (den),
               .quo_out (f_w[lv][i])
            );
         end else begin : g_keep
            assign f_w[lv][i] = f_w[lv-1][i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Piecewise linear value, started with the last level
   // ------------------------------------------------------------------
   seg_type seg_a;
   logic signed [2*DEN_W-1:0] lp_ff;
   logic signed [DEN_W-1:0]   lden_a_ff, lden_b_ff;
   logic signed [NUM_W-1:0]   lnum_ff;
   logic signed [FV_W-1:0]    q_lin;

   assign seg_a = tci_pick_seg(t_lv[NUM_LVL], x1_ff, x2_ff, x3_ff, y1_ff, y2_ff, y3_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         lp_ff     <= tci_diff(seg_a.yb, seg_a.ya) * tci_diff(t_lv[NUM_LVL], seg_a.xa);
         lden_a_ff <= tci_diff(seg_a.xb, seg_a.xa);
         lnum_ff   <= $signed({{(NUM_W-2*DEN_W){lp_ff[2*DEN_W-1]}}, lp_ff});
         lden_b_ff <= lden_a_ff;
      end
   end

   tci_divider u_lin_div (
      .clock   (clock),
      .en      (adv),
      .num_in  (lnum_ff),
      .den_in  (lden_b_ff),
      .quo_out (q_lin)
   );

   // ------------------------------------------------------------------
   // Blend and clamp
   // ------------------------------------------------------------------
   seg_type seg_e;
   logic signed [FV_W-1:0]    lin_in, lin_ff, poly1_ff, poly2_ff, poly3_ff;
   logic signed [FV_W:0]      pl_diff;
   logic signed [NUM_W-1:0]   bprod_ff, bsum;
   logic signed [NUM_W-FRAC_BITS-1:0] sh_ff;
   logic signed [NUM_W-FRAC_BITS:0]   val;
   logic signed [NUM_W-FRAC_BITS:0]   one_v;
   result_type tail_in, tail_ff;

   assign seg_e  = tci_pick_seg(tl_ff[TL_LEN-1], x1_ff, x2_ff, x3_ff, y1_ff, y2_ff, y3_ff);
   assign lin_in = seg_e.eq ? $signed({{(FV_W-FIELD_W){1'b0}}, y1_ff})
                            : $signed({{(FV_W-FIELD_W){1'b0}}, seg_e.ya}) + q_lin;
   assign pl_diff = $signed({poly1_ff[FV_W-1], poly1_ff}) - $signed({lin_ff[FV_W-1], lin_ff});
   // truncate toward zero on the divide by one
   assign bsum   = bprod_ff + (bprod_ff[NUM_W-1] ? $signed(NUM_W'(ONE_Q - 1'b1))
                                                 : $signed(NUM_W'(0)));
   assign one_v  = $signed({{(NUM_W-FRAC_BITS+1-FIELD_W){1'b0}}, ONE_Q});
   assign val    = $signed({{(NUM_W-FRAC_BITS+1-FV_W){poly3_ff[FV_W-1]}}, poly3_ff}) -
                   $signed({sh_ff[NUM_W-FRAC_BITS-1], sh_ff});

   // saturation keeps sign and order, so the clamp reads the raw value
   always_comb begin
      tail_in.degen = 1'b0;
      if (degen) begin
         tail_in.curve   = '0;
         tail_in.clamped = 1'b0;
         tail_in.degen   = 1'b1;
      end else if (val > one_v) begin
         tail_in.curve   = ONE_Q;
         tail_in.clamped = 1'b1;
      end else if (val < 0) begin
         tail_in.curve   = '0;
         tail_in.clamped = 1'b1;
      end else begin
         tail_in.curve   = val[FIELD_W-1:0];
         tail_in.clamped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lin_ff   <= lin_in;
         poly1_ff <= f_w[NUM_LVL][4];
         bprod_ff <= pl_diff * $signed({1'b0, blend_ff});
         poly2_ff <= poly1_ff;
         sh_ff    <= bsum[NUM_W-1:FRAC_BITS];
         poly3_ff <= poly2_ff;
         tail_ff  <= tail_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register and skid entry
   // ------------------------------------------------------------------
   result_type out_ff, skid_ff;
   logic take, tail_v, load_out, load_skid, out_from_skid;

   assign take   = rsp_valid_ff && !rsp_stall;
   assign tail_v = vl_ff[TOTAL_LAT-1] && adv;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_v_in     = skid_v_ff;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      out_from_skid = 1'b0;
      if (skid_v_ff) begin
         if (take) begin
            out_from_skid = 1'b1;
            skid_v_in     = 1'b0;
         end
      end else if (tail_v) begin
         if (!rsp_valid_ff || take) begin
            load_out     = 1'b1;
            rsp_valid_in = 1'b1;
         end else begin
            load_skid = 1'b1;
            skid_v_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_v_ff    <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff <= tail_ff;
      end else if (out_from_skid) begin
         out_ff <= skid_ff;
      end
      if (load_skid) begin
         skid_ff <= tail_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_curve_out        = out_ff.curve;
   assign rsp_was_clamped      = out_ff.clamped;
   assign rsp_degenerate_knots = out_ff.degen;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_valid_ff)
      else $error("skid entry holds a transfer while output register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid entry filled without a stalled result");

   a_curve_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_curve_out <= ONE_Q))
      else $error("curve_out above full scale");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_degenerate_knots) |-> (rsp_curve_out == '0 && !rsp_was_clamped))
      else $error("degenerate knots with nonzero result");

endmodule

// ===== dv/throttle_curve_checker.sv =====
`timescale 1ns / 100ps

module throttle_curve_checker import tci_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [FIELD_W-1:0]   req_throttle_in,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [FIELD_W-1:0]   rsp_curve_out,
   input  logic                 rsp_was_clamped,
   input  logic                 rsp_degenerate_knots,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata,
   output int                   fail_count,
   output int                   pending_count
);

   localparam longint CLIP = (longint'(1) << 36) - 1;
   localparam longint UNIT = longint'(1) << FRAC_BITS;

   logic [FIELD_W-1:0] x1, x2, x3, y1, y2, y3, blend;
   result_type         shaped_q[$];

   function automatic longint clip36(input longint v);
      if (v > CLIP) return CLIP;
      if (v < -CLIP) return -CLIP;
      return v;
   endfunction

   function automatic longint line_at(input longint xa, input longint ya,
                                      input longint xb, input longint yb,
                                      input longint t);
      if (xb == xa) return ya;
      return clip36(ya + ((yb - ya) * (t - xa)) / (xb - xa));
   endfunction

   // expected shaped throttle for one sample under the current knots
   function automatic result_type shape_throttle(input logic [FIELD_W-1:0] thr);
      longint     kx[5], ky[5];
      longint     t, lin, poly, val;
      bit         degen;
      result_type r;
      t = longint'(thr);
      degen = 1'b0;
      kx[0] = 0; kx[1] = longint'(x1); kx[2] = longint'(x2); kx[3] = longint'(x3);
      kx[4] = UNIT;
      ky[0] = 0; ky[1] = longint'(y1); ky[2] = longint'(y2); ky[3] = longint'(y3);
      ky[4] = UNIT;
      for (int a = 0; a < 5; a++)
         for (int b = a + 1; b < 5; b++)
            if (kx[a] == kx[b]) degen = 1'b1;
      r = '0;
      if (degen) begin
         r.degen = 1'b1;
         return r;
      end
      // segment order is fixed, even for knots out of order
      if (t < kx[1]) lin = line_at(kx[0], ky[0], kx[1], ky[1], t);
      else if (t > kx[3]) lin = line_at(kx[3], ky[3], kx[4], ky[4], t);
      else if (t > kx[2]) lin = line_at(kx[2], ky[2], kx[3], ky[3], t);
      else if (t > kx[1]) lin = line_at(kx[1], ky[1], kx[2], ky[2], t);
      else lin = ky[1];
      for (int j = 1; j < 5; j++)
         for (int i = 4; i >= j; i--)
            ky[i] = clip36(((t - kx[i-j]) * ky[i] - (t - kx[i]) * ky[i-1])
                           / (kx[i] - kx[i-j]));
      poly = ky[4];
      val = clip36(poly - ((poly - lin) * longint'(blend)) / UNIT);
      if (val > UNIT) begin
         r.curve = ONE_Q;
         r.clamped = 1'b1;
      end else if (val < 0) begin
         r.clamped = 1'b1;
      end else begin
         r.curve = val[FIELD_W-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      int         errs;
      errs = 0;
      if (reset) begin
         x1 <= RST_KNOT_X1; x2 <= RST_KNOT_X2; x3 <= RST_KNOT_X3;
         y1 <= RST_KNOT_Y1; y2 <= RST_KNOT_Y2; y3 <= RST_KNOT_Y3;
         blend <= RST_BLEND;
         shaped_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_KNOT_X1:      x1 <= csr_wdata;
               CSR_KNOT_X2:      x2 <= csr_wdata;
               CSR_KNOT_X3:      x3 <= csr_wdata;
               CSR_KNOT_Y1:      y1 <= csr_wdata;
               CSR_KNOT_Y2:      y2 <= csr_wdata;
               CSR_KNOT_Y3:      y3 <= csr_wdata;
               CSR_BLEND_FACTOR: blend <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            shaped_q.push_back(shape_throttle(req_throttle_in));
         if (rsp_valid && !rsp_stall) begin
            if (shaped_q.size() == 0) begin
               $error("unexpected result transfer");
               errs++;
            end else begin
               want = shaped_q.pop_front();
               if (rsp_curve_out !== want.curve) begin
                  $error("curve_out: expected %0d, got %0d", want.curve, rsp_curve_out);
                  errs++;
               end
               if (rsp_was_clamped !== want.clamped) begin
                  $error("was_clamped: expected %0d, got %0d", want.clamped,
                         rsp_was_clamped);
                  errs++;
               end
               if (rsp_degenerate_knots !== want.degen) begin
                  $error("degenerate_knots: expected %0d, got %0d", want.degen,
                         rsp_degenerate_knots);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending_count <= shaped_q.size();
   end

endmodule

// ===== dv/throttle_curve_interpolator_test.sv =====
`timescale 1ns / 100ps

module throttle_curve_interpolator_test;
   import tci_pkg::*;

   localparam int NUM_ITEMS   = 1900;
   localparam int CYCLE_LIMIT = 600000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [FIELD_W-1:0]   req_throttle_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [FIELD_W-1:0]   rsp_curve_out;
   logic                 rsp_was_clamped;
   logic                 rsp_degenerate_knots;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FIELD_W-1:0]   csr_wdata;
   int                   fail_count;
   int                   pending_count;
   int                   cycles;
   int                   sent;
   int                   tx_idle_pct;
   int                   rx_idle_pct;
   logic [FIELD_W-1:0]   cur_x1, cur_x2, cur_x3;

   throttle_curve_interpolator i_dut (.*);

   throttle_curve_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver back-pressure; percentage follows the idling schedule
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one sample transfer, with random gaps before it
   task automatic send_throttle(input logic [FIELD_W-1:0] t);
      // idling schedule: sender dense / receiver busy, swapped, then none
      if (sent < NUM_ITEMS / 3) begin
         tx_idle_pct = 14; rx_idle_pct = 65;
      end else if (sent < 2 * NUM_ITEMS / 3) begin
         tx_idle_pct = 65; rx_idle_pct = 14;
      end else begin
         tx_idle_pct = 0; rx_idle_pct = 0;
      end
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_throttle_in <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // drain the pipe so knots may change safely
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TOTAL_LAT + 8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [FIELD_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic load_curve(input logic [FIELD_W-1:0] x1, input logic [FIELD_W-1:0] x2,
                             input logic [FIELD_W-1:0] x3, input logic [FIELD_W-1:0] y1,
                             input logic [FIELD_W-1:0] y2, input logic [FIELD_W-1:0] y3,
                             input logic [FIELD_W-1:0] bf);
      drain();
      write_reg(CSR_KNOT_X1, x1);
      write_reg(CSR_KNOT_X2, x2);
      write_reg(CSR_KNOT_X3, x3);
      write_reg(CSR_KNOT_Y1, y1);
      write_reg(CSR_KNOT_Y2, y2);
      write_reg(CSR_KNOT_Y3, y3);
      write_reg(CSR_BLEND_FACTOR, bf);
      csr_write <= 1'b0;
      cur_x1 = x1; cur_x2 = x2; cur_x3 = x3;
   endtask

   // mostly in-range throttle, sometimes exactly on a knot or above 1.0
   function automatic logic [FIELD_W-1:0] pick_throttle;
      int sel;
      sel = $urandom_range(0, 19);
      case (sel)
         0: return cur_x1;
         1: return cur_x2;
         2: return cur_x3;
         3: return FIELD_W'($urandom_range(0, 131071));
         4: return ONE_Q;
         default: return FIELD_W'($urandom_range(0, 65536));
      endcase
   endfunction

   // random curve: mostly distinct ordered knots, some shuffled,
   // some coinciding, some with the first knot above 1.0
   task automatic load_random_curve;
      logic [FIELD_W-1:0] a, b, c, tmp;
      int                 kind;
      kind = $urandom_range(0, 9);
      a = FIELD_W'($urandom_range(1, 65535));
      b = FIELD_W'($urandom_range(1, 65535));
      c = FIELD_W'($urandom_range(1, 65535));
      if (kind < 6) begin
         if (a > b) begin tmp = a; a = b; b = tmp; end
         if (b > c) begin tmp = b; b = c; c = tmp; end
         if (a > b) begin tmp = a; a = b; b = tmp; end
      end else if (kind == 7) begin
         b = a;
      end else if (kind == 8) begin
         a = FIELD_W'($urandom_range(65537, 131071));
      end
      load_curve(a, b, c, FIELD_W'($urandom_range(0, 131071)),
                 FIELD_W'($urandom_range(0, 65536)), FIELD_W'($urandom_range(0, 65536)),
                 FIELD_W'($urandom_range(0, 131071)));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_throttle_in = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_KNOT_X1;
      csr_wdata = '0;
      cycles = 0;
      sent = 0;
      tx_idle_pct = 14;
      rx_idle_pct = 65;
      cur_x1 = RST_KNOT_X1; cur_x2 = RST_KNOT_X2; cur_x3 = RST_KNOT_X3;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset curve: ends, knots, full 17-bit throttle
      send_throttle('0);
      send_throttle(17'd1);
      send_throttle(RST_KNOT_X1);
      send_throttle(RST_KNOT_X2);
      send_throttle(RST_KNOT_X3);
      send_throttle(ONE_Q);
      send_throttle(17'h1FFFF);

      // strong blend, extreme outputs, clamping both ways
      load_curve(17'd8000, 17'd20000, 17'd60000, 17'h1FFFF, 17'd0, 17'd65536, 17'h1FFFF);
      send_throttle('0);
      send_throttle(17'd8000);
      send_throttle(17'd14000);
      send_throttle(17'd40000);
      send_throttle(17'd62000);
      send_throttle(17'h1FFFF);

      // knots out of order, full blend
      load_curve(17'd50000, 17'd10000, 17'd30000, 17'd0, 17'd65536, 17'd1000,
                 ONE_Q);
      send_throttle(17'd50000);
      send_throttle(17'd20000);
      send_throttle(17'd40000);

      // coinciding knots: on zero, on one, with each other
      load_curve(17'd0, 17'd30000, 17'd40000, 17'd5, 17'd6, 17'd7, 17'd0);
      send_throttle(17'd100);
      load_curve(17'd20000, 17'd30000, ONE_Q, 17'd5, 17'd6, 17'd7, 17'd0);
      send_throttle(17'd100);
      load_curve(17'd20000, 17'd20000, 17'd40000, 17'd5, 17'd6, 17'd7, 17'd0);
      send_throttle(17'd100);
      // knot above 1.0
      load_curve(17'h1FFFF, 17'd30000, 17'd40000, 17'd5, 17'd6, 17'd7, 17'd32768);
      send_throttle(17'd70000);

      // random curves, roughly 200 samples each
      while (sent < NUM_ITEMS) begin
         load_random_curve();
         repeat ($urandom_range(150, 250)) begin
            if (sent < NUM_ITEMS) send_throttle(pick_throttle());
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tci_pkg.sv
rtl/tci_div_cell.sv
rtl/tci_divider.sv
rtl/throttle_curve_interpolator.sv
dv/throttle_curve_checker.sv
dv/throttle_curve_interpolator_test.sv
